/* sv/obde_pkg.sv */
// shared types, opcodes and sizing constants for the occupancy bitmap disc engine
package obde_pkg;

   localparam int DEF_WIDTH  = 1024;
   localparam int DEF_HEIGHT = 512;

   // field widths
   localparam int OP_W    = 2;
   localparam int COORD_W = 12;
   localparam int RAD_W   = 6;
   localparam int ROW_W   = 10;
   // internal signed coordinate width, room for center plus or minus radius
   localparam int CW      = 14;

   localparam logic [OP_W-1:0] OP_CARVE   = 2'd0;
   localparam logic [OP_W-1:0] OP_FILL    = 2'd1;
   localparam logic [OP_W-1:0] OP_COLLIDE = 2'd2;
   localparam logic [OP_W-1:0] OP_GROUND  = 2'd3;

   // controller to datapath commands
   typedef struct packed {
      logic clr;        // write zero at the clearing counter
      logic load;       // take a new request beat
      logic row_start;  // compute remaining squared radius of this row
      logic sqrt_step;  // one bit of the half-width root
      logic span;       // register the clamped span of this row
      logic rd;         // read the addressed word
      logic op;         // check or modify the word just read
      logic row_next;   // advance to the next disc row
      logic gnd_rd;     // read the word holding the ground column
      logic gnd_next;   // advance the ground scan one row
      logic set_hit;    // record a collision
      logic gnd_found;  // record the current scan row as the answer
      logic gnd_none;   // record height as the answer
      logic emit;       // load the response registers
   } obde_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;
      logic is_write;
      logic is_collide;
      logic is_ground;
      logic sqrt_last;
      logic span_skip;
      logic span_hit;
      logic word_hit;
      logic word_last;
      logic row_last;
      logic gnd_oob;
      logic gnd_bit;
      logic gnd_last;
   } obde_sts_type;

endpackage

/* sv/occupancy_bitmap_disc_engine_top.sv */
// disc ops walk up to 127 rows: half-width root, span, then read and check or modify each word
// collide stops at its first hit; ground scans read and test one row at a time, up to HEIGHT rows
// throughput: one item at a time, bounded by the single port of the bitmap memory
// a finished result waits in the output register while the next item is taken
// reset: synchronous; afterwards a clearing pass over all ceil(WIDTH/64) * HEIGHT words
// zeroes the bitmap, during which req_ready stays low
module occupancy_bitmap_disc_engine_top
   import obde_pkg::*;
#(
   parameter int WIDTH  = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [RAD_W-1:0]          req_radius,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic                      rsp_hit,
   output logic [ROW_W-1:0]          rsp_ground_row,
   output logic [OP_W-1:0]           rsp_result_opcode
);

   obde_cmd_type cmd;
   obde_sts_type sts;

   obde_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   obde_datapath #(
      .WIDTH  (WIDTH),
      .HEIGHT (HEIGHT)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_opcode        (req_opcode),
      .req_center_x      (req_center_x),
      .req_center_y      (req_center_y),
      .req_radius        (req_radius),
      .rsp_hit           (rsp_hit),
      .rsp_ground_row    (rsp_ground_row),
      .rsp_result_opcode (rsp_result_opcode)
   );

endmodule

/* sv/obde_datapath.sv */
// datapath: bitmap memory, disc row geometry, word masks and result registers
module obde_datapath
   import obde_pkg::*;
#(
   parameter int WIDTH  = DEF_WIDTH,
   parameter int HEIGHT = DEF_HEIGHT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  obde_cmd_type              cmd,
   output obde_sts_type              sts,
   input  logic [OP_W-1:0]           req_opcode,
   input  logic signed [COORD_W-1:0] req_center_x,
   input  logic signed [COORD_W-1:0] req_center_y,
   input  logic [RAD_W-1:0]          req_radius,
   output logic                      rsp_hit,
   output logic [ROW_W-1:0]          rsp_ground_row,
   output logic [OP_W-1:0]           rsp_result_opcode
);

   localparam int WPR    = (WIDTH + 63) / 64;
   localparam int NWORDS = WPR * HEIGHT;
   localparam int AW     = $clog2(NWORDS);
   localparam int WDW    = (WPR > 1) ? $clog2(WPR) : 1;
   localparam int XW     = $clog2(WIDTH);
   localparam int YW     = $clog2(HEIGHT);
   localparam int R2W    = 2 * RAD_W;
   localparam logic signed [CW-1:0] WIDTH_S  = CW'(WIDTH);
   localparam logic signed [CW-1:0] HEIGHT_S = CW'(HEIGHT);

   logic [63:0] mem [NWORDS];
   logic [63:0] rdata_ff;

   logic [OP_W-1:0]         op_ff;
   logic signed [CW-1:0]    cx_ff, cy_ff;
   logic [RAD_W-1:0]        r_ff;
   logic [R2W-1:0]          r2_ff, rem_ff;
   logic signed [RAD_W:0]   dy_ff;
   logic [RAD_W-1:0]        h_ff;
   logic [2:0]              sbit_ff;
   logic [XW-1:0]           xl_ff, xr_ff;
   logic [WDW-1:0]          wd_ff, wlast_ff;
   logic [AW-1:0]           base_ff;
   logic [YW-1:0]           y_ff;
   logic                    hit_ff;
   logic [ROW_W-1:0]        row_ff;
   logic [AW-1:0]           clr_cnt_ff;
   logic                    rsp_hit_ff;
   logic [ROW_W-1:0]        rsp_row_ff;
   logic [OP_W-1:0]         rsp_op_ff;

   // row geometry
   logic [RAD_W-1:0]        dy_abs;
   logic [R2W-1:0]          dy2;
   logic [RAD_W-1:0]        trial;
   logic [R2W-1:0]          trial2;
   logic signed [CW-1:0]    y_s, xl_s, xr_s;
   logic                    row_oob, left_oob, right_oob;
   logic [XW-1:0]           xl_c, xr_c;

   assign dy_abs = dy_ff[RAD_W] ? RAD_W'(-dy_ff) : RAD_W'(dy_ff);
   assign dy2    = dy_abs * dy_abs;
   assign trial  = h_ff | (RAD_W'(1) << sbit_ff);
   assign trial2 = trial * trial;
   assign y_s    = cy_ff + CW'(dy_ff);
   assign xl_s   = cx_ff - CW'({1'b0, h_ff});
   assign xr_s   = cx_ff + CW'({1'b0, h_ff});
   assign row_oob   = (y_s < 0) || (y_s >= HEIGHT_S);
   assign left_oob  = xl_s < 0;
   assign right_oob = xr_s >= WIDTH_S;
   assign xl_c = left_oob  ? '0 : XW'(xl_s);
   assign xr_c = right_oob ? XW'(WIDTH - 1) : XW'(xr_s);

   // word mask of the span within the current word
   logic [AW-1:0] addr;
   logic [5:0]    lo, hi;
   logic [63:0]   mask, new_word;

   assign addr = base_ff + AW'(wd_ff);
   assign lo   = (WDW'(xl_ff >> 6) == wd_ff) ? xl_ff[5:0] : 6'd0;
   assign hi   = (WDW'(xr_ff >> 6) == wd_ff) ? xr_ff[5:0] : 6'd63;
   assign mask = ({64{1'b1}} << lo) & ({64{1'b1}} >> (6'd63 - hi));
   assign new_word = (op_ff == OP_FILL) ? (rdata_ff | mask) : (rdata_ff & ~mask);

   // status
   always_comb begin
      sts.clr_last   = clr_cnt_ff == AW'(NWORDS - 1);
      sts.is_write   = (op_ff == OP_CARVE) || (op_ff == OP_FILL);
      sts.is_collide = op_ff == OP_COLLIDE;
      sts.is_ground  = op_ff == OP_GROUND;
      sts.sqrt_last  = sbit_ff == 3'd0;
      sts.span_skip  = row_oob || (xr_s < 0) || (xl_s >= WIDTH_S);
      sts.span_hit   = row_oob || left_oob || right_oob;
      sts.word_hit   = (rdata_ff & mask) != '0;
      sts.word_last  = wd_ff == wlast_ff;
      sts.row_last   = dy_ff == $signed({1'b0, r_ff});
      sts.gnd_oob    = (cx_ff < 0) || (cx_ff >= WIDTH_S);
      sts.gnd_bit    = rdata_ff[cx_ff[5:0]];
      sts.gnd_last   = y_ff == YW'(HEIGHT - 1);
   end

   // bitmap memory, one port shared by clear, update and read
   always_ff @(posedge clock) begin
      if (cmd.clr) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.op && sts.is_write) begin
         mem[addr] <= new_word;
      end
      if (cmd.rd || cmd.gnd_rd) begin
         rdata_ff <= mem[addr];
      end
   end

   // clearing counter
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clr) begin
         clr_cnt_ff <= clr_cnt_ff + AW'(1);
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_opcode;
         cx_ff   <= CW'(req_center_x);
         cy_ff   <= CW'(req_center_y);
         r_ff    <= req_radius;
         r2_ff   <= req_radius * req_radius;
         dy_ff   <= -$signed({1'b0, req_radius});
         hit_ff  <= 1'b0;
         row_ff  <= '0;
         y_ff    <= '0;
         base_ff <= '0;
         wd_ff   <= WDW'($unsigned(req_center_x) >> 6);
      end
      if (cmd.row_start) begin
         rem_ff  <= r2_ff - dy2;
         h_ff    <= '0;
         sbit_ff <= 3'(RAD_W - 1);
      end
      if (cmd.sqrt_step) begin
         if (trial2 <= rem_ff) begin
            h_ff <= trial;
         end
         sbit_ff <= sbit_ff - 3'd1;
      end
      if (cmd.span) begin
         xl_ff    <= xl_c;
         xr_ff    <= xr_c;
         wd_ff    <= WDW'(xl_c >> 6);
         wlast_ff <= WDW'(xr_c >> 6);
         base_ff  <= AW'($unsigned(YW'(y_s)) * WPR);
      end
      if (cmd.op && !sts.word_last) begin
         wd_ff <= wd_ff + WDW'(1);
      end
      if (cmd.row_next) begin
         dy_ff <= dy_ff + (RAD_W+1)'(1);
      end
      if (cmd.gnd_next) begin
         y_ff    <= y_ff + YW'(1);
         base_ff <= base_ff + AW'(WPR);
      end
      if (cmd.set_hit) begin
         hit_ff <= 1'b1;
      end
      if (cmd.gnd_found) begin
         row_ff <= ROW_W'(y_ff);
      end
      if (cmd.gnd_none) begin
         row_ff <= ROW_W'(HEIGHT);
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_hit_ff <= hit_ff;
         rsp_row_ff <= row_ff;
         rsp_op_ff  <= op_ff;
      end
   end

   assign rsp_hit           = rsp_hit_ff;
   assign rsp_ground_row    = rsp_row_ff;
   assign rsp_result_opcode = rsp_op_ff;

endmodule

/* sv/obde_ctrl.sv */
// controller: sequences clearing, disc row walks and ground scans
module obde_ctrl
   import obde_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  obde_sts_type sts,
   output obde_cmd_type cmd
);

   localparam logic [3:0] S_CLR  = 4'd0;
   localparam logic [3:0] S_IDLE = 4'd1;
   localparam logic [3:0] S_DISP = 4'd2;
   localparam logic [3:0] S_ROW  = 4'd3;
   localparam logic [3:0] S_SQRT = 4'd4;
   localparam logic [3:0] S_SPAN = 4'd5;
   localparam logic [3:0] S_RD   = 4'd6;
   localparam logic [3:0] S_OP   = 4'd7;
   localparam logic [3:0] S_GRD  = 4'd8;
   localparam logic [3:0] S_GOP  = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_CLR: begin
            cmd.clr = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!sts.is_ground) begin
               state_in = S_ROW;
            end else if (sts.gnd_oob) begin
               cmd.gnd_none = 1'b1;
               state_in     = S_DONE;
            end else begin
               state_in = S_GRD;
            end
         end
         S_ROW: begin
            cmd.row_start = 1'b1;
            state_in      = S_SQRT;
         end
         S_SQRT: begin
            cmd.sqrt_step = 1'b1;
            if (sts.sqrt_last) begin
               state_in = S_SPAN;
            end
         end
         S_SPAN: begin
            cmd.span = 1'b1;
            priority if (sts.is_collide && sts.span_hit) begin
               cmd.set_hit = 1'b1;
               state_in    = S_DONE;
            end else if (sts.span_skip) begin
               if (sts.row_last) begin
                  state_in = S_DONE;
               end else begin
                  cmd.row_next = 1'b1;
                  state_in     = S_ROW;
               end
            end else begin
               state_in = S_RD;
            end
         end
         S_RD: begin
            cmd.rd   = 1'b1;
            state_in = S_OP;
         end
         S_OP: begin
            cmd.op = 1'b1;
            priority if (sts.is_collide && sts.word_hit) begin
               cmd.set_hit = 1'b1;
               state_in    = S_DONE;
            end else if (!sts.word_last) begin
               state_in = S_RD;
            end else if (sts.row_last) begin
               state_in = S_DONE;
            end else begin
               cmd.row_next = 1'b1;
               state_in     = S_ROW;
            end
         end
         S_GRD: begin
            cmd.gnd_rd = 1'b1;
            state_in   = S_GOP;
         end
         S_GOP: begin
            priority if (sts.gnd_bit) begin
               cmd.gnd_found = 1'b1;
               state_in      = S_DONE;
            end else if (sts.gnd_last) begin
               cmd.gnd_none = 1'b1;
               state_in     = S_DONE;
            end else begin
               cmd.gnd_next = 1'b1;
               state_in     = S_GRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.emit     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLR;
         end
      endcase
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/obde_checker.sv */
// port-level checker for the disc engine and its bind to the top level
module obde_checker
   import obde_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_hit,
   input logic [ROW_W-1:0]  rsp_ground_row,
   input logic [OP_W-1:0]   rsp_result_opcode
);

   // clearing pass blocks requests right after reset
   a_clear_blocks: assert property (@(posedge clock) reset |=> !req_ready && !rsp_valid)
      else $error("request taken or response shown right after reset");

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit)
         && $stable(rsp_ground_row) && $stable(rsp_result_opcode))
      else $error("response beat changed while stalled");

   // only collide reports a hit
   a_hit_only_collide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_opcode != OP_COLLIDE |-> !rsp_hit)
      else $error("hit set on a non-collide response");

   // only ground reports a row
   a_row_only_ground: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_opcode != OP_GROUND |-> rsp_ground_row == '0)
      else $error("ground row set on a non-ground response");

endmodule

bind occupancy_bitmap_disc_engine_top obde_checker u_obde_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_hit           (rsp_hit),
   .rsp_ground_row    (rsp_ground_row),
   .rsp_result_opcode (rsp_result_opcode)
);

/* test/tb_occupancy_bitmap_disc_engine_top.sv */
// testbench for the occupancy bitmap disc engine: directed and random disc and ground beats
`timescale 1ns / 1ps
module tb_occupancy_bitmap_disc_engine_top;
   import obde_pkg::*;

   localparam int WIDTH      = DEF_WIDTH;
   localparam int HEIGHT     = DEF_HEIGHT;
   localparam int CYCLE_MAX  = 10000000;

   typedef struct packed {
      logic              hit;
      logic [ROW_W-1:0]  ground_row;
      logic [OP_W-1:0]   opcode;
   } answer_type;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_ready;
   logic [OP_W-1:0]           req_opcode;
   logic signed [COORD_W-1:0] req_center_x;
   logic signed [COORD_W-1:0] req_center_y;
   logic [RAD_W-1:0]          req_radius;
   logic                      rsp_valid;
   logic                      rsp_ready;
   logic                      rsp_hit;
   logic [ROW_W-1:0]          rsp_ground_row;
   logic [OP_W-1:0]           rsp_result_opcode;

   // predicted bitmap and expected answers
   bit          terrain [HEIGHT][WIDTH];
   answer_type  pending_answers [$];
   int          error_count;
   int          cycle_count;
   int          answers_seen;
   int          beats_sent;

   occupancy_bitmap_disc_engine_top #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_opcode(req_opcode), .req_center_x(req_center_x),
      .req_center_y(req_center_y), .req_radius(req_radius),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_hit(rsp_hit), .rsp_ground_row(rsp_ground_row),
      .rsp_result_opcode(rsp_result_opcode)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // random gap length, mostly short and sometimes long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 45) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // apply one beat to the predicted bitmap and return its answer
   function automatic answer_type predict_beat(logic [OP_W-1:0] op, int cx, int cy, int r);
      answer_type a;
      int x;
      int y;
      a = '0;
      a.opcode = op;
      if (op == OP_GROUND) begin
         a.ground_row = HEIGHT[ROW_W-1:0];
         if (cx >= 0 && cx < WIDTH) begin
            for (y = HEIGHT - 1; y >= 0; y--)
               if (terrain[y][cx]) a.ground_row = y[ROW_W-1:0];
         end
      end else begin
         for (int dy = -r; dy <= r; dy++) begin
            for (int dx = -r; dx <= r; dx++) begin
               if (dx * dx + dy * dy > r * r) continue;
               x = cx + dx;
               y = cy + dy;
               if (x >= 0 && x < WIDTH && y >= 0 && y < HEIGHT) begin
                  if (op == OP_CARVE) terrain[y][x] = 1'b0;
                  else if (op == OP_FILL) terrain[y][x] = 1'b1;
                  else if (terrain[y][x]) a.hit = 1'b1;
               end else if (op == OP_COLLIDE) begin
                  a.hit = 1'b1;
               end
            end
         end
      end
      return a;
   endfunction

   // send one request beat and record its expected answer
   // valid is left high after acceptance; the next call or the caller drops it
   task automatic send_beat(logic [OP_W-1:0] op, int cx, int cy, int r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_center_x <= cx[COORD_W-1:0];
      req_center_y <= cy[COORD_W-1:0];
      req_radius   <= r[RAD_W-1:0];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_answers.push_back(predict_beat(op, cx, cy, r));
      beats_sent++;
   endtask

   // result side: random stalls on rsp_ready
   initial begin
      int stall;
      rsp_ready = 1'b0;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // compare each accepted result beat with the oldest expectation
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         answers_seen++;
         if (pending_answers.size() == 0) begin
            $error("result beat with no expectation, opcode %0d", rsp_result_opcode);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_result_opcode !== want.opcode) begin
               $error("result_opcode expected %0d actual %0d", want.opcode, rsp_result_opcode);
               error_count++;
            end
            if (rsp_hit !== want.hit) begin
               $error("hit expected %0d actual %0d", want.hit, rsp_hit);
               error_count++;
            end
            if (rsp_ground_row !== want.ground_row) begin
               $error("ground_row expected %0d actual %0d", want.ground_row, rsp_ground_row);
               error_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_MAX) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // extremes of every field and each edge case
   task automatic test_directed();
      send_beat(OP_GROUND, 10, 0, 0);            // empty column
      send_beat(OP_COLLIDE, 100, 100, 5);        // empty area, no hit
      send_beat(OP_COLLIDE, 0, 0, 0);            // corner single pixel
      send_beat(OP_COLLIDE, 0, 0, 1);            // partly outside
      send_beat(OP_FILL, 200, 300, 63);          // largest disc
      send_beat(OP_GROUND, 200, 0, 0);
      send_beat(OP_GROUND, 263, 0, 0);
      send_beat(OP_CARVE, 200, 300, 10);
      send_beat(OP_GROUND, 200, 0, 0);
      send_beat(OP_COLLIDE, 200, 300, 10);       // edge of carved hole
      send_beat(OP_COLLIDE, 200, 300, 9);
      send_beat(OP_FILL, WIDTH - 1, HEIGHT - 1, 3);
      send_beat(OP_GROUND, WIDTH - 1, 0, 0);
      send_beat(OP_GROUND, WIDTH, 0, 0);         // column past the right edge
      send_beat(OP_GROUND, -1, 0, 0);            // negative column
      send_beat(OP_GROUND, -2048, -2048, 63);
      send_beat(OP_GROUND, 2047, 2047, 63);
      send_beat(OP_FILL, -2048, -2048, 63);      // fully outside, no change
      send_beat(OP_FILL, 2047, 2047, 63);
      send_beat(OP_COLLIDE, -2048, 2047, 63);
      send_beat(OP_CARVE, 0, 0, 0);
      send_beat(OP_FILL, 5, -3, 4);              // clipped at the top
      send_beat(OP_GROUND, 5, 0, 0);
      send_beat(OP_CARVE, 200, 300, 63);
   endtask

   // random beats, mostly in or near the bitmap with small radii
   task automatic test_random(int count);
      int op;
      int cx;
      int cy;
      int r;
      for (int n = 0; n < count; n++) begin
         op = $urandom_range(0, 3);
         if ($urandom_range(0, 9) == 0) begin
            cx = $signed($urandom_range(0, 4095) - 2048);
            cy = $signed($urandom_range(0, 4095) - 2048);
         end else begin
            cx = $urandom_range(0, WIDTH + 40) - 20;
            cy = $urandom_range(0, HEIGHT + 40) - 20;
         end
         r = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 12);
         send_beat(op[OP_W-1:0], cx, cy, r);
      end
   endtask

   initial begin
      int settle;
      error_count   = 0;
      cycle_count   = 0;
      answers_seen  = 0;
      beats_sent    = 0;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_CARVE;
      req_center_x  = '0;
      req_center_y  = '0;
      req_radius    = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(900);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      settle = 0;
      while (settle < 2 * HEIGHT + 100) begin
         @(posedge clock);
         settle++;
      end
      $display("run covered %0d request beats and %0d checked answers", beats_sent, answers_seen);
      $display("carve, fill, collide and ground beats with clipped and off-map discs");
      if (error_count == 0 && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

/* occupancy_bitmap_disc_engine_top.f */
sv/obde_pkg.sv
sv/obde_datapath.sv
sv/obde_ctrl.sv
sv/occupancy_bitmap_disc_engine_top.sv
sv/obde_checker.sv
test/tb_occupancy_bitmap_disc_engine_top.sv
